FILE: rtl/usph_pkg.sv
package usph_pkg;

    localparam int COUNT_BITS = 8;

    localparam int DIV_NW = 25;
    localparam int DIV_DW = COUNT_BITS + 1;
    localparam int DIV_LAT = DIV_NW;
    localparam int SIN_LAT = 5;
    localparam int MATH_LAT = 3;
    localparam int FRONT_LAT = DIV_LAT + SIN_LAT + MATH_LAT;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W = 4;

    localparam logic [30:0] SIN_A = 31'd1685472549;
    localparam logic [29:0] SIN_B = 30'd686590538;
    localparam logic [26:0] SIN_C = 27'd74859813;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_CELL   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] REG_STACK  = 2'd0;
    localparam logic [1:0] REG_SECTOR = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic [COUNT_BITS-1:0] stack_count;
        logic [COUNT_BITS-1:0] sector_count;
        logic [15:0]           sphere_radius;
    } usph_cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [15:0] k1;
        logic [15:0] k2;
        logic        upper;
        logic        lower;
    } usph_item_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [15:0] vertex_index;
        logic        last;
        logic        status;
    } usph_result_t;

endpackage

FILE: rtl/uv_sphere_tessellator.sv
// channel   dir   handshake                     word
// request   in    push / full                   opcode, stack_index, sector_index
// result    out   pop / empty                   pos_*, norm_*, tex_*, vertex_index, last, status
// config    in    psel, penable, pwrite, pready paddr, pwdata / prdata
//
// one request per clock while full is low; a vertex or error gives one word, a cell up to six
// words at one a clock while pop frees the output register; a push reaches empty low through a
// 25-stage divider, 5-stage sine, 3 product stages, the queue and the output register
// reset clears valid bits and queue pointers, config returns to 18 / 36 / 256
// the front pipeline freezes while its last word finds the 4-entry queue full; full is high then
module uv_sphere_tessellator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           opcode,
    input  logic [7:0]                     stack_index,
    input  logic [7:0]                     sector_index,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [15:0]             pos_x,
    output logic signed [15:0]             pos_y,
    output logic signed [15:0]             pos_z,
    output logic signed [15:0]             norm_x,
    output logic signed [15:0]             norm_y,
    output logic signed [15:0]             norm_z,
    output logic [15:0]                    tex_u,
    output logic [15:0]                    tex_v,
    output logic [15:0]                    vertex_index,
    output logic                           last,
    output logic                           status,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [usph_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import usph_pkg::*;

    logic [COUNT_BITS-1:0] stack_count_reg;
    logic [COUNT_BITS-1:0] sector_count_reg;
    logic [15:0]           sphere_radius_reg;
    usph_cfg_t             cfg;
    logic                  cfg_wr;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    usph_item_t            q_item;
    usph_item_t            q_head;
    usph_result_t          word;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg   <= COUNT_BITS'(18);
            sector_count_reg  <= COUNT_BITS'(36);
            sphere_radius_reg <= 16'd256;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_STACK:  stack_count_reg   <= pwdata[COUNT_BITS-1:0];
                REG_SECTOR: sector_count_reg  <= pwdata[COUNT_BITS-1:0];
                REG_RADIUS: sphere_radius_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_STACK:  prdata = 32'(stack_count_reg);
            REG_SECTOR: prdata = 32'(sector_count_reg);
            REG_RADIUS: prdata = 32'(sphere_radius_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.stack_count   = stack_count_reg;
    assign cfg.sector_count  = sector_count_reg;
    assign cfg.sphere_radius = sphere_radius_reg;

    usph_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .opcode       (opcode),
        .stack_index  (stack_index),
        .sector_index (sector_index),
        .cfg          (cfg),
        .q_full       (q_full),
        .full         (full),
        .q_push       (q_push),
        .q_item       (q_item)
    );

    usph_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    usph_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .word    (word)
    );

    assign pos_x        = word.pos_x;
    assign pos_y        = word.pos_y;
    assign pos_z        = word.pos_z;
    assign norm_x       = word.norm_x;
    assign norm_y       = word.norm_y;
    assign norm_z       = word.norm_z;
    assign tex_u        = word.tex_u;
    assign tex_v        = word.tex_v;
    assign vertex_index = word.vertex_index;
    assign last         = word.last;
    assign status       = word.status;

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> last)
        else $error("error word without last");

    a_cell_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=> !empty)
        else $error("gap inside a cell's corner list");

    a_geometry_only_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (norm_z != 16'sd0 || tex_u != 16'd0))
        |-> (last && !status && vertex_index == 16'd0))
        else $error("geometry on a non-vertex word");

endmodule

FILE: rtl/usph_div.sv
module usph_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [usph_pkg::DIV_NW-1:0]  num,
    input  logic [usph_pkg::DIV_DW-1:0]  den,
    output logic [usph_pkg::DIV_NW-1:0]  quot
);
    import usph_pkg::*;

    logic [DIV_NW-1:0] num_reg  [DIV_NW];
    logic [DIV_DW-1:0] den_reg  [DIV_NW];
    logic [DIV_DW-1:0] rem_reg  [DIV_NW];
    logic [DIV_NW-1:0] quot_reg [DIV_NW];

    // one quotient bit per stage
    for (genvar s = 0; s < DIV_NW; s++)
    begin : g_stage
        logic [DIV_NW-1:0] num_in;
        logic [DIV_NW-1:0] quot_in;
        logic [DIV_DW-1:0] den_in;
        logic [DIV_DW-1:0] rem_in;
        logic [DIV_DW:0]   trial;
        logic              take;
        logic [DIV_DW-1:0] rem_next;

        if (s == 0)
        begin : g_first
            assign num_in  = num;
            assign den_in  = den;
            assign rem_in  = '0;
            assign quot_in = '0;
        end
        else
        begin : g_rest
            assign num_in  = num_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign quot_in = quot_reg[s-1];
        end

        assign trial    = {rem_in, num_in[DIV_NW-1-s]};
        assign take     = trial >= {1'b0, den_in};
        assign rem_next = take ? DIV_DW'(trial - {1'b0, den_in}) : trial[DIV_DW-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s]  <= num_in;
                den_reg[s]  <= den_in;
                rem_reg[s]  <= rem_next;
                quot_reg[s] <= {quot_in[DIV_NW-2:0], take};
            end
        end
    end

    assign quot = quot_reg[DIV_NW-1];

endmodule

FILE: rtl/usph_sin.sv
module usph_sin (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        phase,
    output logic signed [15:0] value
);
    import usph_pkg::*;

    logic [16:0]        x_next;
    logic [16:0]        xa_reg;
    logic               nega_reg;
    logic [33:0]        sq;
    logic [16:0]        x2_next;
    logic [16:0]        x2b_reg;
    logic [16:0]        xb_reg;
    logic               negb_reg;
    logic [43:0]        tc;
    logic [29:0]        inner_next;
    logic [29:0]        innerc_reg;
    logic [16:0]        x2c_reg;
    logic [16:0]        xc_reg;
    logic               negc_reg;
    logic [46:0]        tp;
    logic [30:0]        poly_next;
    logic [30:0]        polyd_reg;
    logic [16:0]        xd_reg;
    logic               negd_reg;
    logic [47:0]        tm;
    logic [15:0]        mag;
    logic signed [15:0] value_next;
    logic signed [15:0] value_reg;

    // fold quadrant onto a quarter wave
    assign x_next = phase[14] ? 17'(17'd65536 - {1'b0, phase[13:0], 2'b00})
                              : {1'b0, phase[13:0], 2'b00};

    assign sq         = xa_reg * xa_reg;
    assign x2_next    = sq[32:16];
    assign tc         = x2b_reg * SIN_C;
    assign inner_next = SIN_B - 30'(tc[43:16]);
    assign tp         = x2c_reg * innerc_reg;
    assign poly_next  = SIN_A - 31'(tp[46:16]);
    assign tm         = 48'(xd_reg * polyd_reg) + 48'h0000_8000_0000;
    assign mag        = (tm[47:32] > 16'd16384) ? 16'd16384 : tm[47:32];
    assign value_next = negd_reg ? -$signed(mag) : $signed(mag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg     <= x_next;
            nega_reg   <= phase[15];
            x2b_reg    <= x2_next;
            xb_reg     <= xa_reg;
            negb_reg   <= nega_reg;
            innerc_reg <= inner_next;
            x2c_reg    <= x2b_reg;
            xc_reg     <= xb_reg;
            negc_reg   <= negb_reg;
            polyd_reg  <= poly_next;
            xd_reg     <= xc_reg;
            negd_reg   <= negc_reg;
            value_reg  <= value_next;
        end
    end

    assign value = value_reg;

endmodule

FILE: rtl/usph_front.sv
module usph_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   opcode,
    input  logic [7:0]             stack_index,
    input  logic [7:0]             sector_index,
    input  usph_pkg::usph_cfg_t    cfg,
    input  logic                   q_full,
    output logic                   full,
    output logic                   q_push,
    output usph_pkg::usph_item_t   q_item
);
    import usph_pkg::*;

    localparam int P1 = DIV_LAT + SIN_LAT;

    logic                 adv;
    logic                 accept;
    logic [FRONT_LAT-1:0] vld_reg;
    usph_item_t           side_reg [FRONT_LAT];
    usph_item_t           side_next [FRONT_LAT];
    usph_item_t           entry;
    logic [15:0]          i_w;
    logic [15:0]          j_w;
    logic [15:0]          st_w;
    logic [15:0]          se_w;
    logic                 ok;
    logic [15:0]          k1;
    logic [DIV_NW-1:0]    num_u;
    logic [DIV_NW-1:0]    num_a;
    logic [DIV_NW-1:0]    num_t;
    logic [DIV_DW-1:0]    den_se;
    logic [DIV_DW-1:0]    den_st;
    logic [DIV_NW-1:0]    qu;
    logic [DIV_NW-1:0]    qa;
    logic [DIV_NW-1:0]    qt;
    logic [15:0]          tex_u_next;
    logic [15:0]          tex_v_next;
    logic signed [15:0]   sa;
    logic signed [15:0]   ca;
    logic signed [15:0]   sv;
    logic signed [15:0]   cv;
    logic signed [16:0]   r_s;
    logic signed [31:0]   pc_next;
    logic signed [31:0]   ps_next;
    logic signed [32:0]   pz_next;
    logic signed [31:0]   pc_reg;
    logic signed [31:0]   ps_reg;
    logic signed [32:0]   pz_reg;
    logic signed [48:0]   qx_next;
    logic signed [48:0]   qy_next;
    logic signed [48:0]   qx_reg;
    logic signed [48:0]   qy_reg;
    logic signed [31:0]   nx_rnd;
    logic signed [31:0]   ny_rnd;
    logic signed [32:0]   pz_rnd;
    logic signed [48:0]   qx_rnd;
    logic signed [48:0]   qy_rnd;

    function automatic logic [15:0] sat16(input logic signed [48:0] v);
        logic [15:0] r;
        if (v > 49'sd32767)
            r = 16'h7FFF;
        else if (v < -49'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    assign adv    = !(vld_reg[FRONT_LAT-1] && q_full);
    assign full   = !adv;
    assign accept = push && adv;
    assign q_push = vld_reg[FRONT_LAT-1] && adv;
    assign q_item = side_reg[FRONT_LAT-1];

    // classify
    assign i_w  = 16'(stack_index);
    assign j_w  = 16'(sector_index);
    assign st_w = 16'(cfg.stack_count);
    assign se_w = 16'(cfg.sector_count);

    always_comb
    begin
        if (!opcode)
            ok = (st_w != 16'd0) && (se_w != 16'd0) && (i_w <= st_w) && (j_w <= se_w);
        else
            ok = (st_w != 16'd0) && (se_w != 16'd0) && (i_w < st_w) && (j_w < se_w);
    end

    assign k1 = 16'(i_w * (se_w + 16'd1) + j_w);

    always_comb
    begin
        entry       = '0;
        entry.kind  = !ok ? KIND_ERROR : (opcode ? KIND_CELL : KIND_VERTEX);
        entry.k1    = k1;
        entry.k2    = 16'(k1 + se_w + 16'd1);
        entry.upper = i_w != 16'd0;
        entry.lower = i_w != 16'(st_w - 16'd1);
    end

    // rounded ratios
    assign num_u  = DIV_NW'({sector_index, 17'd0}) + DIV_NW'(cfg.sector_count);
    assign num_a  = DIV_NW'({stack_index, 16'd0}) + DIV_NW'(cfg.stack_count);
    assign num_t  = DIV_NW'({stack_index, 17'd0}) + DIV_NW'(cfg.stack_count);
    assign den_se = {cfg.sector_count, 1'b0};
    assign den_st = {cfg.stack_count, 1'b0};

    usph_div u_div_u (.clk(clk), .en(adv), .num(num_u), .den(den_se), .quot(qu));
    usph_div u_div_a (.clk(clk), .en(adv), .num(num_a), .den(den_st), .quot(qa));
    usph_div u_div_t (.clk(clk), .en(adv), .num(num_t), .den(den_st), .quot(qt));

    assign tex_u_next = (qu[DIV_NW-1:16] != '0) ? 16'hFFFF : qu[15:0];
    assign tex_v_next = (qt[DIV_NW-1:16] != '0) ? 16'hFFFF : qt[15:0];

    usph_sin u_sin_a (.clk(clk), .en(adv), .phase(qa[15:0]), .value(sa));
    usph_sin u_cos_a (.clk(clk), .en(adv), .phase(16'(qa[15:0] + 16'd16384)), .value(ca));
    usph_sin u_sin_v (.clk(clk), .en(adv), .phase(qu[15:0]), .value(sv));
    usph_sin u_cos_v (.clk(clk), .en(adv), .phase(16'(qu[15:0] + 16'd16384)), .value(cv));

    // position and normal products
    assign r_s     = {1'b0, cfg.sphere_radius};
    assign pc_next = sa * cv;
    assign ps_next = sa * sv;
    assign pz_next = r_s * ca;
    assign qx_next = r_s * pc_reg;
    assign qy_next = r_s * ps_reg;
    assign nx_rnd  = (pc_reg + 32'sd8192) >>> 14;
    assign ny_rnd  = (ps_reg + 32'sd8192) >>> 14;
    assign pz_rnd  = (pz_reg + 33'sd8192) >>> 14;
    assign qx_rnd  = (qx_reg + 49'sd134217728) >>> 28;
    assign qy_rnd  = (qy_reg + 49'sd134217728) >>> 28;

    always_comb
    begin
        side_next[0] = entry;
        for (int s = 1; s < FRONT_LAT; s++)
        begin
            side_next[s] = side_reg[s-1];
        end
        side_next[DIV_LAT].tex_u = tex_u_next;
        side_next[DIV_LAT].tex_v = tex_v_next;
        side_next[P1].norm_z     = ca;
        side_next[P1+1].norm_x   = sat16(49'(nx_rnd));
        side_next[P1+1].norm_y   = sat16(49'(ny_rnd));
        side_next[P1+1].pos_z    = sat16(49'(pz_rnd));
        side_next[P1+2].pos_x    = sat16(qx_rnd);
        side_next[P1+2].pos_y    = sat16(qy_rnd);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pc_reg <= pc_next;
            ps_reg <= ps_next;
            pz_reg <= pz_next;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            for (int s = 0; s < FRONT_LAT; s++)
            begin
                side_reg[s] <= side_next[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[FRONT_LAT-2:0], accept};
    end

endmodule

FILE: rtl/usph_queue.sv
module usph_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  usph_pkg::usph_item_t  push_item,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output usph_pkg::usph_item_t  head
);
    import usph_pkg::*;

    usph_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/usph_back.sv
module usph_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  usph_pkg::usph_item_t    q_head,
    output logic                    q_pop,
    input  logic                    pop,
    output logic                    empty,
    output usph_pkg::usph_result_t  word
);
    import usph_pkg::*;

    logic         out_vld_reg;
    usph_result_t out_reg;
    usph_result_t result_next;
    logic         started_reg;
    logic [2:0]   pos_reg;
    logic [2:0]   pos;
    logic [2:0]   start;
    logic [2:0]   stop;
    logic         is_cell;
    logic         none;
    logic         fin;
    logic         can_load;
    logic         emit;
    logic [15:0]  corner;

    assign is_cell  = q_head.kind == KIND_CELL;
    assign start    = q_head.upper ? 3'd0 : 3'd3;
    assign stop     = q_head.lower ? 3'd5 : 3'd2;
    assign none     = is_cell && !q_head.upper && !q_head.lower;
    assign pos      = started_reg ? pos_reg : start;
    assign fin      = !is_cell || (pos == stop);
    assign can_load = !out_vld_reg || pop;
    assign emit     = !q_empty && !none && can_load;
    assign q_pop    = !q_empty && (none || (can_load && fin));

    // upper triangle then lower triangle
    always_comb
    begin
        case (pos)
            3'd0:    corner = q_head.k1;
            3'd1:    corner = q_head.k2;
            3'd2:    corner = 16'(q_head.k1 + 16'd1);
            3'd3:    corner = 16'(q_head.k1 + 16'd1);
            3'd4:    corner = q_head.k2;
            3'd5:    corner = 16'(q_head.k2 + 16'd1);
            default: corner = q_head.k1;
        endcase
    end

    always_comb
    begin
        result_next = '0;
        case (q_head.kind)
            KIND_VERTEX:
            begin
                result_next.pos_x  = q_head.pos_x;
                result_next.pos_y  = q_head.pos_y;
                result_next.pos_z  = q_head.pos_z;
                result_next.norm_x = q_head.norm_x;
                result_next.norm_y = q_head.norm_y;
                result_next.norm_z = q_head.norm_z;
                result_next.tex_u  = q_head.tex_u;
                result_next.tex_v  = q_head.tex_v;
                result_next.last   = 1'b1;
            end
            KIND_CELL:
            begin
                result_next.vertex_index = corner;
                result_next.last         = fin;
            end
            default:
            begin
                result_next.last   = 1'b1;
                result_next.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            started_reg <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            if (can_load)
                out_vld_reg <= emit;
            if (emit)
            begin
                if (fin)
                    started_reg <= 1'b0;
                else
                begin
                    started_reg <= 1'b1;
                    pos_reg     <= 3'(pos + 3'd1);
                end
            end
        end
    end

    assign empty = !out_vld_reg;
    assign word  = out_reg;

endmodule

FILE: verif/tb.sv
module tb;
    import usph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int SETTLE_CYCLES  = 60;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 opcode;
    logic [7:0]           stack_index;
    logic [7:0]           sector_index;
    logic                 empty;
    logic                 pop;
    logic signed [15:0]   pos_x, pos_y, pos_z;
    logic signed [15:0]   norm_x, norm_y, norm_z;
    logic [15:0]          tex_u, tex_v, vertex_index;
    logic                 last, status;
    logic                 psel, penable, pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    uv_sphere_tessellator dut (.*);

    usph_result_t expected_words[$];
    int unsigned  cfg_stacks;
    int unsigned  cfg_sectors;
    int unsigned  cfg_radius;
    int           mismatches;
    int           cycle_count;
    int           rx_hold;
    int           burst_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // sine math mirrors the block's fixed-point polynomial
    function automatic longint quarter_wave(longint unsigned x);
        longint unsigned x2, inner, poly, s;
        x2    = (x * x) >> 16;
        inner = longint'(SIN_B) - ((x2 * longint'(SIN_C)) >> 16);
        poly  = longint'(SIN_A) - ((x2 * inner) >> 16);
        s     = (x * poly + (64'd1 << 31)) >> 32;
        if (s > 16384)
            s = 16384;
        return longint'(s);
    endfunction

    function automatic longint sine_of_phase(int unsigned phase);
        int unsigned     q;
        longint unsigned f;
        longint          m;
        q = (phase >> 14) & 3;
        f = longint'(phase & 16'h3FFF) << 2;
        m = q[0] ? quarter_wave(65536 - f) : quarter_wave(f);
        return q[1] ? -m : m;
    endfunction

    function automatic longint cosine_of_phase(int unsigned phase);
        return sine_of_phase((phase + 16384) & 16'hFFFF);
    endfunction

    function automatic longint unsigned scaled_ratio(longint unsigned n, longint unsigned scale,
                                                     longint unsigned d);
        return (n * scale * 2 + d) / (2 * d);
    endfunction

    function automatic longint shift_round(longint t, int sh);
        return (t + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic [15:0] clamp_s16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [15:0] clamp_u16(longint unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic predict_words(logic op, logic [7:0] i, logic [7:0] j);
        usph_result_t    w;
        bit              ok;
        int unsigned     pv, pa;
        longint          sa, ca, sv, cv, r;
        longint unsigned k1, k2;
        longint unsigned idx[$];
        w = '0;
        if (op == 1'b0)
            ok = cfg_stacks != 0 && cfg_sectors != 0 && i <= cfg_stacks && j <= cfg_sectors;
        else
            ok = cfg_stacks != 0 && cfg_sectors != 0 && i < cfg_stacks && j < cfg_sectors;
        if (!ok)
        begin
            w.last   = 1'b1;
            w.status = 1'b1;
            expected_words = {expected_words, w};
        end
        else if (op == 1'b0)
        begin
            pv = 32'(scaled_ratio(j, 65536, cfg_sectors) & 16'hFFFF);
            pa = 32'(scaled_ratio(i, 32768, cfg_stacks));
            sa = sine_of_phase(pa);
            ca = cosine_of_phase(pa);
            sv = sine_of_phase(pv);
            cv = cosine_of_phase(pv);
            r  = cfg_radius;
            w.pos_x  = clamp_s16(shift_round(r * sa * cv, 28));
            w.pos_y  = clamp_s16(shift_round(r * sa * sv, 28));
            w.pos_z  = clamp_s16(shift_round(r * ca, 14));
            w.norm_x = clamp_s16(shift_round(sa * cv, 14));
            w.norm_y = clamp_s16(shift_round(sa * sv, 14));
            w.norm_z = clamp_s16(ca);
            w.tex_u  = clamp_u16(scaled_ratio(j, 65536, cfg_sectors));
            w.tex_v  = clamp_u16(scaled_ratio(i, 65536, cfg_stacks));
            w.last   = 1'b1;
            expected_words = {expected_words, w};
        end
        else
        begin
            k1 = i * (cfg_sectors + 1) + j;
            k2 = k1 + cfg_sectors + 1;
            if (i != 0)
            begin
                idx = {idx, k1};
                idx = {idx, k2};
                idx = {idx, k1 + 1};
            end
            if (i != cfg_stacks - 1)
            begin
                idx = {idx, k1 + 1};
                idx = {idx, k2};
                idx = {idx, k2 + 1};
            end
            foreach (idx[k])
            begin
                w = '0;
                w.vertex_index = idx[k][15:0];
                w.last = (k == idx.size() - 1);
                expected_words = {expected_words, w};
            end
        end
    endtask

    // sender: bursts with random gaps, push held high across back-to-back words
    task automatic send_word(logic op, logic [7:0] i, logic [7:0] j);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        push         <= 1'b1;
        opcode       <= op;
        stack_index  <= i;
        sector_index <= j;
        do
            @(posedge clk);
        while (full);
        predict_words(op, i, j);
        burst_left--;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        burst_left = 0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(int unsigned index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * index);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_STACK:  cfg_stacks  = value & ((1 << COUNT_BITS) - 1);
            REG_SECTOR: cfg_sectors = value & ((1 << COUNT_BITS) - 1);
            REG_RADIUS: cfg_radius  = value & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_grid(int unsigned st, int unsigned se, int unsigned rad);
        wait_idle();
        write_reg(REG_STACK, st);
        write_reg(REG_SECTOR, se);
        write_reg(REG_RADIUS, rad);
    endtask

    // mostly in-grid requests, some anywhere in the index range
    task automatic send_random();
        logic [7:0] i, j;
        logic       op;
        op = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < 15 || cfg_stacks == 0 || cfg_sectors == 0)
        begin
            i = $urandom_range(0, 255);
            j = $urandom_range(0, 255);
        end
        else
        begin
            i = $urandom_range(0, cfg_stacks);
            j = $urandom_range(0, cfg_sectors);
        end
        send_word(op, i, j);
    endtask

    task automatic test_defaults();
        send_word(1'b0, 8'd0, 8'd0);
        send_word(1'b0, 8'd18, 8'd36);
        send_word(1'b0, 8'd9, 8'd9);
        send_word(1'b0, 8'd19, 8'd0);
        send_word(1'b0, 8'd0, 8'd37);
        send_word(1'b0, 8'd255, 8'd255);
        send_word(1'b1, 8'd0, 8'd0);
        send_word(1'b1, 8'd17, 8'd35);
        send_word(1'b1, 8'd5, 8'd20);
        send_word(1'b1, 8'd18, 8'd0);
        send_word(1'b1, 8'd0, 8'd36);
    endtask

    task automatic test_corner_grids();
        set_grid(1, 1, 256);
        send_word(1'b1, 8'd0, 8'd0);
        send_word(1'b0, 8'd1, 8'd1);
        send_word(1'b0, 8'd0, 8'd0);
        set_grid(0, 36, 256);
        send_word(1'b0, 8'd0, 8'd0);
        send_word(1'b1, 8'd0, 8'd0);
        set_grid(18, 0, 256);
        send_word(1'b0, 8'd0, 8'd0);
        set_grid(32'h1FF, 255, 65535);
        write_reg(3, 32'hFFFF_FFFF);
        send_word(1'b0, 8'd128, 8'd32);
        send_word(1'b0, 8'd64, 8'd0);
        send_word(1'b1, 8'd254, 8'd254);
        send_word(1'b0, 8'd255, 8'd255);
        set_grid(7, 3, 0);
        send_word(1'b0, 8'd3, 8'd1);
        send_word(1'b1, 8'd6, 8'd2);
    endtask

    task automatic test_random();
        int unsigned st, se;
        for (int phase = 0; phase < 8; phase++)
        begin
            st = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20);
            se = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 40);
            set_grid(st, se, $urandom_range(0, 65535));
            repeat (33) send_random();
        end
    endtask

    task automatic test_backpressure();
        set_grid(12, 24, 512);
        rx_hold = 400;
        repeat (40) send_random();
        wait_idle();
        repeat (30) send_random();
    endtask

    // receiver: stall pattern rotates through always, random and sparse pop, after any rx_hold pause
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            pop     <= 1'b0;
        end
        else
        begin
            case ((cycle_count / 64) % 3)
                0: pop <= 1'b1;
                1: pop <= $urandom_range(0, 1);
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result check against the oldest expected word
    always @(posedge clk)
    begin
        usph_result_t got;
        if (rst_n && pop && !empty)
        begin
            got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                    vertex_index, last, status};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", got);
            end
            else
            begin
                if (got !== expected_words[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", expected_words[0], got);
                end
                void'(expected_words.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        opcode       = 1'b0;
        stack_index  = '0;
        sector_index = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cycle_count  = 0;
        mismatches   = 0;
        rx_hold      = 0;
        burst_left   = 0;
        cfg_stacks   = 18;
        cfg_sectors  = 36;
        cfg_radius   = 256;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_corner_grids();
        test_random();
        test_backpressure();
        wait_idle();
        if (mismatches == 0 && expected_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/usph_pkg.sv
rtl/usph_div.sv
rtl/usph_sin.sv
rtl/usph_front.sv
rtl/usph_queue.sv
rtl/usph_back.sv
rtl/uv_sphere_tessellator.sv
verif/tb.sv
